// ===== sv/ghmm_pkg.sv =====
package ghmm_pkg;

    // ecu state codes
    localparam logic [2:0] ECU_ABSENT  = 3'd0;
    localparam logic [2:0] ECU_START1  = 3'd1;
    localparam logic [2:0] ECU_START2  = 3'd2;
    localparam logic [2:0] ECU_RUN     = 3'd3;
    localparam logic [2:0] ECU_SHUTDN  = 3'd4;
    localparam logic [2:0] ECU_SLEEP   = 3'd5;
    localparam logic [2:0] ECU_OFF     = 3'd6;
    localparam logic [2:0] ECU_OTHER   = 3'd7;

    // comm mode codes
    localparam logic [1:0] COMM_ABSENT = 2'd0;
    localparam logic [1:0] COMM_NONE   = 2'd1;
    localparam logic [1:0] COMM_SILENT = 2'd2;
    localparam logic [1:0] COMM_FULL   = 2'd3;

    // application bridge codes
    localparam logic [1:0] APP_ABSENT   = 2'd0;
    localparam logic [1:0] APP_NOTREADY = 2'd1;
    localparam logic [1:0] APP_READY    = 2'd2;
    localparam logic [1:0] APP_DEGRADED = 2'd3;

    // profile codes
    localparam logic [1:0] PROF_NORMAL   = 2'd0;
    localparam logic [1:0] PROF_DEGRADED = 2'd1;
    localparam logic [1:0] PROF_DIAG     = 2'd2;

    // gateway command codes
    localparam logic [2:0] CMD_NONE     = 3'd0;
    localparam logic [2:0] CMD_HOLD     = 3'd1;
    localparam logic [2:0] CMD_NO_COMM  = 3'd2;
    localparam logic [2:0] CMD_NORMAL   = 3'd3;
    localparam logic [2:0] CMD_DEGRADED = 3'd4;
    localparam logic [2:0] CMD_DIAG     = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_CAN_LIMIT  = 2'd0;
    localparam logic [1:0] CFG_ETH_LIMIT  = 2'd1;
    localparam logic [1:0] CFG_AUTH_LIMIT = 2'd2;
    localparam logic [1:0] CFG_RECOV_LIMIT = 2'd3;

    // limit reset values
    localparam logic [7:0] CAN_LIMIT_RST   = 8'd3;
    localparam logic [7:0] ETH_LIMIT_RST   = 8'd3;
    localparam logic [7:0] AUTH_LIMIT_RST  = 8'd5;
    localparam logic [7:0] RECOV_LIMIT_RST = 8'd5;

    typedef struct packed {
        logic comm;
        logic eth;
        logic nroute;
        logic droute;
        logic degev;
        logic diagev;
    } levels_t;

endpackage

// ===== sv/gateway_health_mode_manager.sv =====
// a request is held in the input register, then its result in the result register
// throughput: one request per cycle; input register and result register are split by
// a single stage of compare/increment logic, and the counters close their loop there
// the input side stalls only while a held result is stalled and the input register is full
// reset (rst_n low, asynchronous): counters zero, profile normal, command none, all
// action levels off, limits back to 3/3/5/5, both stages empty
module gateway_health_mode_manager
    import ghmm_pkg::*;
#(
    parameter int COUNT_MAX = 255
)
(
    input  logic       clk,
    input  logic       rst_n,
    // configuration
    input  logic       cfg_write_en,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    // tick snapshot channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] ecu_state,
    input  logic [1:0] comm_mode,
    input  logic [1:0] comm_desired,
    input  logic       can_fault,
    input  logic       eth_offline,
    input  logic       auth_failure,
    input  logic [1:0] app_state,
    // result channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] profile,
    output logic       profile_changed,
    output logic [2:0] command,
    output logic       command_changed,
    output logic       comm_full_request,
    output logic       eth_full_request,
    output logic       normal_route_on,
    output logic       diag_route_on,
    output logic       degraded_event_failed,
    output logic       diag_event_failed
);

    // counter width follows the saturation point; compares run at the wider of it and 8
    localparam int CountW = $clog2(COUNT_MAX + 1);
    localparam int CmpW   = (CountW > 8) ? CountW : 8;
    localparam logic [CountW-1:0] CountMax = CountW'(COUNT_MAX);

    // configuration limits
    logic [7:0] can_limit_reg, eth_limit_reg, auth_limit_reg, recov_limit_reg;

    // health state
    logic [CountW-1:0] can_cnt_reg, eth_cnt_reg, auth_cnt_reg, recov_cnt_reg;
    logic [CountW-1:0] can_cnt_next, eth_cnt_next, auth_cnt_next, recov_cnt_next;
    logic [1:0]        cur_prof_reg, cur_prof_next;
    logic [2:0]        last_cmd_reg, last_cmd_next;
    levels_t           levels_reg, levels_next;

    // input register
    logic       in_vld_reg;
    logic [2:0] ecu_reg;
    logic [1:0] cm_reg, cd_reg, app_reg;
    logic       canf_reg, ethf_reg, authf_reg;

    // result register
    logic       out_vld_reg;
    logic [1:0] prof_out_reg;
    logic       pchg_out_reg, cchg_out_reg;
    logic [2:0] cmd_out_reg;
    levels_t    lv_out_reg;

    logic advance;
    logic out_free;

    // computed per tick
    logic       demanded, app_ready;
    logic       over_can, over_eth, over_auth, over_recov;
    logic       pchg, cchg;
    logic [1:0] cd_eff;
    logic [2:0] cmd;
    levels_t    lv_prof;

    function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] v);
        return (v < CountMax) ? v + 1'b1 : CountMax;
    endfunction

    // levels for a given profile, event bits untouched
    function automatic levels_t drive_prof(input levels_t lv, input logic [1:0] prof,
                                           input logic ready);
        levels_t r;
        r        = lv;
        r.comm   = 1'b1;
        r.eth    = 1'b1;
        r.nroute = (prof != PROF_DIAG) && ready;
        r.droute = (prof != PROF_NORMAL);
        return r;
    endfunction

    // handshake: result register frees when empty or taken this cycle
    assign out_free = !out_vld_reg || !out_stall;
    assign advance  = in_vld_reg && out_free;
    assign in_stall = in_vld_reg && !out_free;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            can_limit_reg   <= CAN_LIMIT_RST;
            eth_limit_reg   <= ETH_LIMIT_RST;
            auth_limit_reg  <= AUTH_LIMIT_RST;
            recov_limit_reg <= RECOV_LIMIT_RST;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_CAN_LIMIT:   can_limit_reg   <= cfg_data;
                CFG_ETH_LIMIT:   eth_limit_reg   <= cfg_data;
                CFG_AUTH_LIMIT:  auth_limit_reg  <= cfg_data;
                CFG_RECOV_LIMIT: recov_limit_reg <= cfg_data;
                default:         can_limit_reg   <= can_limit_reg;
            endcase
        end
    end

    // input register: loads whenever it is empty or moving on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            ecu_reg   <= ecu_state;
            cm_reg    <= comm_mode;
            cd_reg    <= comm_desired;
            canf_reg  <= can_fault;
            ethf_reg  <= eth_offline;
            authf_reg <= auth_failure;
            app_reg   <= app_state;
        end
    end

    // health counters and profile selection
    always_comb
    begin
        demanded  = (ecu_reg == ECU_RUN) && (cm_reg == COMM_FULL);
        app_ready = (app_reg == APP_READY);

        can_cnt_next  = (demanded && canf_reg)  ? sat_inc(can_cnt_reg)  : '0;
        eth_cnt_next  = (demanded && ethf_reg)  ? sat_inc(eth_cnt_reg)  : '0;
        auth_cnt_next = (demanded && authf_reg) ? sat_inc(auth_cnt_reg) : '0;

        over_can   = CmpW'(can_cnt_next)  >= CmpW'(can_limit_reg);
        over_eth   = CmpW'(eth_cnt_next)  >= CmpW'(eth_limit_reg);
        over_auth  = CmpW'(auth_cnt_next) >= CmpW'(auth_limit_reg);

        cur_prof_next  = cur_prof_reg;
        recov_cnt_next = '0;
        over_recov     = 1'b0;
        if (demanded)
        begin
            if (over_auth || (over_can && over_eth))
            begin
                cur_prof_next = PROF_DIAG;
            end
            else if (over_can || over_eth)
            begin
                cur_prof_next = PROF_DEGRADED;
            end
            else
            begin
                recov_cnt_next = sat_inc(recov_cnt_reg);
                over_recov     = CmpW'(recov_cnt_next) >= CmpW'(recov_limit_reg);
                if (over_recov)
                begin
                    cur_prof_next = PROF_NORMAL;
                end
            end
        end
        pchg = (cur_prof_next != cur_prof_reg);

        // profile change drives levels and diagnostic events
        lv_prof = levels_reg;
        if (pchg)
        begin
            lv_prof = drive_prof(levels_reg, cur_prof_next, app_ready);
            case (cur_prof_next)
                PROF_NORMAL:
                begin
                    lv_prof.degev  = 1'b0;
                    lv_prof.diagev = 1'b0;
                end
                PROF_DEGRADED:
                begin
                    lv_prof.degev  = 1'b1;
                    lv_prof.diagev = 1'b0;
                end
                default:
                begin
                    // degraded event is left as it was
                    lv_prof.diagev = 1'b1;
                end
            endcase
        end
    end

    // gateway command and its actions
    always_comb
    begin
        // desired comm falls back to the reported one when absent
        cd_eff = (cd_reg == COMM_ABSENT) ? cm_reg : cd_reg;

        unique case (ecu_reg) inside
            ECU_ABSENT:             cmd = CMD_NONE;
            ECU_START1, ECU_START2: cmd = CMD_HOLD;
            ECU_RUN:
            begin
                if ((cd_eff == COMM_NONE) || (cd_eff == COMM_SILENT))
                    cmd = CMD_NO_COMM;
                else if (app_reg == APP_NOTREADY)
                    cmd = CMD_NO_COMM;
                else if (app_reg == APP_DEGRADED)
                    cmd = CMD_DIAG;
                else if (cur_prof_next == PROF_DIAG)
                    cmd = CMD_DIAG;
                else if (cur_prof_next == PROF_DEGRADED)
                    cmd = CMD_DEGRADED;
                else
                    cmd = CMD_NORMAL;
            end
            ECU_SHUTDN, ECU_SLEEP, ECU_OFF, ECU_OTHER: cmd = CMD_NO_COMM;
            default:                cmd = CMD_NO_COMM;
        endcase

        cchg          = (cmd != last_cmd_reg);
        last_cmd_next = cmd;
        levels_next   = lv_prof;
        if (cchg)
        begin
            case (cmd)
                CMD_HOLD:
                begin
                    levels_next.nroute = 1'b0;
                    levels_next.droute = 1'b0;
                    levels_next.eth    = 1'b0;
                end
                CMD_NO_COMM:
                begin
                    levels_next.comm   = 1'b0;
                    levels_next.nroute = 1'b0;
                    levels_next.droute = 1'b0;
                    levels_next.eth    = 1'b0;
                end
                CMD_NORMAL:   levels_next = drive_prof(lv_prof, PROF_NORMAL, app_ready);
                CMD_DEGRADED: levels_next = drive_prof(lv_prof, PROF_DEGRADED, app_ready);
                CMD_DIAG:     levels_next = drive_prof(lv_prof, PROF_DIAG, app_ready);
                default:      levels_next = lv_prof; // none drives nothing
            endcase
        end
    end

    // health state commits as a request moves into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            can_cnt_reg   <= '0;
            eth_cnt_reg   <= '0;
            auth_cnt_reg  <= '0;
            recov_cnt_reg <= '0;
            cur_prof_reg  <= PROF_NORMAL;
            last_cmd_reg  <= CMD_NONE;
            levels_reg    <= '0;
        end
        else if (advance)
        begin
            can_cnt_reg   <= can_cnt_next;
            eth_cnt_reg   <= eth_cnt_next;
            auth_cnt_reg  <= auth_cnt_next;
            recov_cnt_reg <= recov_cnt_next;
            cur_prof_reg  <= cur_prof_next;
            last_cmd_reg  <= last_cmd_next;
            levels_reg    <= levels_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_vld_reg <= advance;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prof_out_reg <= cur_prof_next;
            pchg_out_reg <= pchg;
            cmd_out_reg  <= cmd;
            cchg_out_reg <= cchg;
            lv_out_reg   <= levels_next;
        end
    end

    assign out_valid             = out_vld_reg;
    assign profile               = prof_out_reg;
    assign profile_changed       = pchg_out_reg;
    assign command               = cmd_out_reg;
    assign command_changed       = cchg_out_reg;
    assign comm_full_request     = lv_out_reg.comm;
    assign eth_full_request      = lv_out_reg.eth;
    assign normal_route_on       = lv_out_reg.nroute;
    assign diag_route_on         = lv_out_reg.droute;
    assign degraded_event_failed = lv_out_reg.degev;
    assign diag_event_failed     = lv_out_reg.diagev;

`ifndef SYNTHESIS
    // input side only holds back while a full result is stalled
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_vld_reg && out_stall && in_vld_reg))
        else $error("input stalled without a stalled result");

    // profile never leaves its three codes
    a_prof_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (prof_out_reg != 2'd3))
        else $error("profile code out of range");

    // a fresh diag-only profile always raises its event
    a_diag_event: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && pchg_out_reg && (prof_out_reg == PROF_DIAG)) |-> lv_out_reg.diagev)
        else $error("diag-only change without diag event");

    // a new no-comm command drops comm, ethernet and routing
    a_no_comm: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && cchg_out_reg && (cmd_out_reg == CMD_NO_COMM))
            |-> !(lv_out_reg.comm || lv_out_reg.eth || lv_out_reg.nroute
                  || lv_out_reg.droute))
        else $error("no-comm command left levels on");

    // state only moves with a request passing into the result register
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(last_cmd_reg) && $stable(cur_prof_reg))
        else $error("health state changed without a request");
`endif

endmodule
